### hw/rtl/dle_unstuffing_packet_deframer_macros.svh
// Assertion macros for the deframer checker.
`ifndef DLE_UNSTUFFING_PACKET_DEFRAMER_MACROS_SVH
`define DLE_UNSTUFFING_PACKET_DEFRAMER_MACROS_SVH

// Check a property on the rising clock, ignored while reset is held.
`define DUPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock, also during reset.
`define DUPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dupd_pkg.sv
// Package with framing codes and defaults for the DLE unstuffing deframer.
package dupd_pkg;

    localparam logic [7:0] START_BYTE = 8'hF2;
    localparam logic [7:0] END_BYTE   = 8'hF3;
    localparam logic [7:0] ESC_BYTE   = 8'hF0;

    localparam int DEF_STORE_DEPTH = 60;
    localparam int DEF_INDEX_LIMIT = 58;

    localparam int PKT_INDEX_W = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

endpackage

### hw/rtl/dupd_store.sv
// Packet store: one write port and one registered read port.
module dupd_store #(
    parameter int DEPTH  = 60,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/dle_unstuffing_packet_deframer.sv
// DLE byte-unstuffing packet deframer: top level.
//
// Input channel (i_t*): one raw link byte per item in i_tdata, i_tlast marks
// the end of a delivered chunk and has no effect on framing. 0xF2 starts a
// packet, 0xF0 escapes the next byte (stored ORed with 0xF0), and 0xF3 ends
// the packet. A write index above INDEX_LIMIT restarts the buffer.
// Output channel (o_t*): on each end byte the stored packet, start and end
// bytes included, is sent one byte per item, with its position in
// o_tdata[13:8] and o_tlast on the final byte.
// Flow: a byte that does not end a packet is handled and the block stays
// ready for the next byte. An end byte is stored, then each packet byte is
// read from the store's read port (ST_READ) and shown (ST_SHOW) until the
// receiver takes it, so the input is held off until the whole packet has
// been sent. The first output item is shown after the end byte is stored
// and the first packet byte has been read.
// Input is not taken during a burst; a stalled receiver holds the current
// item steady. Reset clears the write index, the escape flag and the burst
// state; store contents stay undefined until written.
module dle_unstuffing_packet_deframer
    import dupd_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int INDEX_LIMIT = DEF_INDEX_LIMIT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // rx_byte[7:0]
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    input  logic                   i_tlast,
    input  logic                   i_tvalid,
    output logic                   i_tready,
    // pkt_byte[7:0], pkt_index[13:8], zero[15:14]
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast,
    output logic                   o_tvalid,
    input  logic                   o_tready
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int IDX_W  = $clog2(INDEX_LIMIT + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_esc, n_esc;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_zero, n_zero;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [7:0]         rd_data;

    logic [7:0]         rx_byte;
    logic               accept;
    logic [IDX_W-1:0]   idx_g;
    logic               esc_g;
    logic               idx_in_store;
    logic               k_last;
    logic [7:0]         pkt_byte;

    assign rx_byte      = i_tdata[7:0];
    assign accept       = i_tvalid && i_tready;
    assign idx_g        = (r_idx > IDX_W'(INDEX_LIMIT)) ? '0 : r_idx;
    assign esc_g        = (r_idx > IDX_W'(INDEX_LIMIT)) ? 1'b0 : r_esc;
    assign idx_in_store = (32'(idx_g) < STORE_DEPTH);
    assign k_last       = ((r_k + 1'b1) == r_idx);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_esc   = r_esc;
        n_k     = r_k;
        n_zero  = r_zero;
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(idx_g);
        wr_data = rx_byte;
        rd_en   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = idx_g;
                    n_esc = esc_g;
                    if (rx_byte == START_BYTE) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        n_idx   = IDX_W'(1);
                        n_esc   = 1'b0;
                    end else if (rx_byte == END_BYTE) begin
                        // store the end byte raw, then walk the buffer
                        wr_en   = idx_in_store;
                        n_idx   = idx_g + 1'b1;
                        n_k     = '0;
                        n_state = ST_READ;
                    end else if (!esc_g) begin
                        if (rx_byte == ESC_BYTE) begin
                            n_esc = 1'b1;
                        end else begin
                            wr_en = idx_in_store;
                            n_idx = idx_g + 1'b1;
                        end
                    end else begin
                        wr_en   = idx_in_store;
                        wr_data = ESC_BYTE | rx_byte;
                        n_idx   = idx_g + 1'b1;
                        n_esc   = 1'b0;
                    end
                end
            end
            ST_READ: begin
                n_zero  = !(32'(r_k) < STORE_DEPTH);
                rd_en   = (32'(r_k) < STORE_DEPTH);
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (o_tready) begin
                    if (k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_esc   <= 1'b0;
            r_k     <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_esc   <= n_esc;
            r_k     <= n_k;
            r_zero  <= n_zero;
        end
    end

    dupd_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (ADDR_W'(r_k)),
        .o_rd_data (rd_data)
    );

    assign pkt_byte = r_zero ? 8'h00 : rd_data;

    assign i_tready = (r_state == ST_IDLE);
    assign o_tvalid = (r_state == ST_SHOW);
    assign o_tlast  = k_last;
    assign o_tdata  = {2'b00, PKT_INDEX_W'(r_k), pkt_byte};

endmodule

### hw/rtl/dupd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "dle_unstuffing_packet_deframer_macros.svh"

module dupd_checker
    import dupd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic [IN_TDATA_W-1:0]  i_tdata,
    input logic                   i_tvalid,
    input logic                   i_tready,
    input logic [OUT_TDATA_W-1:0] o_tdata,
    input logic                   o_tlast,
    input logic                   o_tvalid,
    input logic                   o_tready
);

    // no input is taken while a packet is being sent
    `DUPD_ASSERT(a_no_input_in_burst, i_clk, i_rst_n, o_tvalid |-> !i_tready, "input ready during burst")

    // an accepted end byte starts a burst, so input goes idle
    `DUPD_ASSERT(a_end_goes_busy, i_clk, i_rst_n, (i_tvalid && i_tready && i_tdata[7:0] == END_BYTE) |=> !i_tready, "end byte did not start a burst")

    // the last item of a burst ends output
    `DUPD_ASSERT(a_last_ends_burst, i_clk, i_rst_n, (o_tvalid && o_tready && o_tlast) |=> !o_tvalid, "output continued after last item")

    // hold a stalled output item
    `DUPD_ASSERT(a_stall_holds, i_clk, i_rst_n, (o_tvalid && !o_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_tlast)), "stalled output item changed")

    // reset leaves no output pending
    `DUPD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_tvalid, "output valid after reset")

endmodule

bind dle_unstuffing_packet_deframer dupd_checker u_dupd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tdata  (i_tdata),
    .i_tvalid (i_tvalid),
    .i_tready (i_tready),
    .o_tdata  (o_tdata),
    .o_tlast  (o_tlast),
    .o_tvalid (o_tvalid),
    .o_tready (o_tready)
);
